// File: src/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types and constants of the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam int unsigned GROUP_SIZE = 4;

    localparam logic [7:0] SPACE_BYTE    = 8'h20;
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD2_LO      = 8'hC2;
    localparam logic [7:0] LEAD2_HI      = 8'hDF;
    localparam logic [7:0] LEAD3_LO      = 8'hE0;
    localparam logic [7:0] LEAD3_HI      = 8'hEF;
    localparam logic [7:0] LEAD4_LO      = 8'hF0;
    localparam logic [7:0] LEAD4_HI      = 8'hF4;
    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] CONT_PATTERN  = 8'h80;

    // One input byte expands into a group of one to four output bytes.
    typedef struct packed {
        logic [GROUP_SIZE-1:0][7:0] data;
        logic [1:0]                 last_idx;  // index of the final byte in the group
        logic                       last;      // group closes the string
    } group_t;

endpackage

// File: src/utf8s_decode.sv
// ----------------------------------------------------------------------------
// utf8s_decode
// Sequence tracker: holds a pending lead and its continuations, and turns
// each accepted byte that completes or breaks a sequence into a group of output bytes.
// ----------------------------------------------------------------------------
module utf8s_decode
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output group_t     grp,
    output logic       grp_valid
);

    logic [7:0] held_lead_reg, held_lead_next;
    logic [7:0] held_cont_reg [3];
    logic [1:0] cont_seen_reg, cont_seen_next;
    logic [1:0] cont_needed_reg, cont_needed_next;
    logic       cont_we;

    logic [1:0] fresh_need;
    logic       fresh_emits;
    logic [7:0] fresh_val;
    logic       is_cont;
    logic [2:0] seen_inc;
    logic [2:0] count;

    always_comb
    begin
        fresh_need = 2'd0;
        if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI)
        begin
            fresh_need = 2'd1;
        end
        else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI)
        begin
            fresh_need = 2'd2;
        end
        else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI)
        begin
            fresh_need = 2'd3;
        end
    end

    assign fresh_emits = (in_byte < ASCII_LIMIT) || (fresh_need == 2'd0) || in_last;
    assign fresh_val   = (in_byte < ASCII_LIMIT) ? in_byte : SPACE_BYTE;
    assign is_cont     = (in_byte & CONT_MASK) == CONT_PATTERN;
    assign seen_inc    = {1'b0, cont_seen_reg} + 3'd1;

    always_comb
    begin
        grp.data         = {GROUP_SIZE{SPACE_BYTE}};
        count            = 3'd0;
        held_lead_next   = held_lead_reg;
        cont_seen_next   = cont_seen_reg;
        cont_needed_next = cont_needed_reg;
        cont_we          = 1'b0;

        if (cont_needed_reg != 2'd0)
        begin
            if (is_cont)
            begin
                cont_we = 1'b1;
                if (seen_inc >= {1'b0, cont_needed_reg})
                begin
                    // sequence complete: lead, buffered bytes, then this byte
                    grp.data[0]             = held_lead_reg;
                    grp.data[1]             = held_cont_reg[0];
                    grp.data[2]             = held_cont_reg[1];
                    grp.data[3]             = held_cont_reg[2];
                    grp.data[seen_inc[1:0]] = in_byte;
                    count                   = seen_inc + 3'd1;
                    cont_seen_next          = 2'd0;
                    cont_needed_next        = 2'd0;
                    held_lead_next          = 8'h00;
                end
                else if (in_last)
                begin
                    // string ends mid-sequence: all spaces
                    count            = seen_inc + 3'd1;
                    cont_seen_next   = 2'd0;
                    cont_needed_next = 2'd0;
                    held_lead_next   = 8'h00;
                end
                else
                begin
                    cont_seen_next = seen_inc[1:0];
                end
            end
            else
            begin
                // broken sequence: spaces, then judge this byte afresh
                count            = seen_inc;
                cont_seen_next   = 2'd0;
                cont_needed_next = 2'd0;
                held_lead_next   = 8'h00;
                if (fresh_emits)
                begin
                    grp.data[seen_inc[1:0]] = fresh_val;
                    count                   = seen_inc + 3'd1;
                end
                else
                begin
                    held_lead_next   = in_byte;
                    cont_needed_next = fresh_need;
                end
            end
        end
        else
        begin
            if (fresh_emits)
            begin
                grp.data[0] = fresh_val;
                count       = 3'd1;
            end
            else
            begin
                held_lead_next   = in_byte;
                cont_seen_next   = 2'd0;
                cont_needed_next = fresh_need;
            end
        end

        grp.last_idx = 2'(count - 3'd1);
        grp.last     = in_last;
        grp_valid    = count != 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg   <= 8'h00;
            cont_seen_reg   <= 2'd0;
            cont_needed_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_lead_reg   <= held_lead_next;
            cont_seen_reg   <= cont_seen_next;
            cont_needed_reg <= cont_needed_next;
        end
    end

    // continuation buffer: no reset, each entry written before it is read
    always_ff @(posedge clk)
    begin
        if (accept && cont_we && cont_seen_reg != 2'd3)
        begin
            held_cont_reg[cont_seen_reg] <= in_byte;
        end
    end

endmodule

// File: src/utf8s_serializer.sv
// ----------------------------------------------------------------------------
// utf8s_serializer
// Result register: holds one byte group and sends it one byte per transfer.
// ----------------------------------------------------------------------------
module utf8s_serializer
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  group_t     grp,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte,
    output logic       m_last
);

    group_t     group_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       at_end;

    assign at_end  = idx_reg == group_reg.last_idx;
    assign free    = !valid_reg || (m_ready && at_end);
    assign m_valid = valid_reg;
    assign m_byte  = group_reg.data[idx_reg];
    assign m_last  = group_reg.last && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (free)
        begin
            // take the next group, or go empty
            valid_reg <= load;
            idx_reg   <= 2'd0;
        end
        else if (m_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            group_reg <= grp;
        end
    end

endmodule

// File: src/utf8_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Streaming UTF-8 cleaner: passes valid sequences, replaces bad bytes by
// spaces.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw byte per transfer; s_axis_tlast marks the final
//   byte of a string. m_axis carries the cleaned bytes; m_axis_tlast marks
//   the final output byte of the string.
//   A byte that completes nothing (a lead or an inner continuation) produces
//   no output. A byte that completes or breaks a sequence produces a group
//   of one to four output bytes, which appear in the cycle after the input
//   transfer and leave at one byte per cycle while m_axis_tready is high.
//   Throughput: one input byte per cycle while groups are single bytes and
//   m_axis_tready is high; a longer group holds the output register until
//   its last byte leaves, and a new byte is taken in the cycle that byte leaves.
//   Reset clears the pending sequence and empties the output register.
//   While the receiver holds m_axis_tready low, the output byte holds and
//   s_axis_tready falls once the pending group cannot be replaced.
// ----------------------------------------------------------------------------
module utf8_sanitizer
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    group_t grp;
    logic   grp_valid;
    logic   free;
    logic   accept;

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    utf8s_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .grp       (grp),
        .grp_valid (grp_valid)
    );

    utf8s_serializer u_serializer (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept && grp_valid),
        .grp     (grp),
        .free    (free),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_byte  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

// File: dv/utf8_sanitizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer_tb
// Drives raw byte strings into the UTF-8 sanitizer. Each accepted byte runs
// through a local cleaner model. Every cleaned byte that leaves the block is
// compared in order, data and tlast, with the bytes that the model expects.
// ----------------------------------------------------------------------------
module utf8_sanitizer_tb
    import utf8s_pkg::*;
;

    localparam int unsigned RANDOM_BYTES = 290;
    localparam int unsigned STALL_AT     = 120;
    localparam int unsigned PAUSE_AT     = 220;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef enum int unsigned {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR,
        CH_NOISE,
        CH_CUT,
        CH_STRAY
    } char_kind_e;

    class clean_byte_board;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
        } clean_byte_t;

        clean_byte_t  clean_due[$];
        clean_byte_t  step_bytes[$];
        logic [7:0]   lead_byte;
        logic [7:0]   cont_buf [3];
        int unsigned  conts_got;
        int unsigned  conts_owed;
        int unsigned  raw_count;
        int unsigned  clean_count;
        int unsigned  string_count;
        int unsigned  errors;

        function new();
            lead_byte    = '0;
            cont_buf     = '{default: '0};
            conts_got    = 0;
            conts_owed   = 0;
            raw_count    = 0;
            clean_count  = 0;
            string_count = 0;
            errors       = 0;
        endfunction

        function void emit(logic [7:0] b);
            clean_byte_t cb;
            cb.data = b;
            cb.last = 1'b0;
            step_bytes.push_back(cb);
        endfunction

        // Replace the pending lead and its buffered continuations by spaces.
        function void flush_broken();
            int unsigned k;
            emit(SPACE_BYTE);
            for (k = 0; k < conts_got && k < 3; k++)
                emit(SPACE_BYTE);
            lead_byte  = '0;
            conts_got  = 0;
            conts_owed = 0;
        endfunction

        function void take_fresh(logic [7:0] b, logic l);
            int unsigned need;
            need = 0;
            if (b < ASCII_LIMIT)
            begin
                emit(b);
                return;
            end
            if (b >= LEAD2_LO && b <= LEAD2_HI)
                need = 1;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
                need = 2;
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
                need = 3;
            if (need == 0 || l)
                emit(SPACE_BYTE);
            else
            begin
                lead_byte  = b;
                conts_got  = 0;
                conts_owed = need;
            end
        endfunction

        function void take_raw_byte(logic [7:0] b, logic l);
            int unsigned k;
            step_bytes.delete();
            raw_count++;
            if (l)
                string_count++;
            if (conts_owed != 0)
            begin
                if ((b & CONT_MASK) == CONT_PATTERN)
                begin
                    if (conts_got < 3)
                        cont_buf[conts_got] = b;
                    conts_got++;
                    if (conts_got >= conts_owed)
                    begin
                        emit(lead_byte);
                        for (k = 0; k < conts_got && k < 3; k++)
                            emit(cont_buf[k]);
                        lead_byte  = '0;
                        conts_got  = 0;
                        conts_owed = 0;
                    end
                    else if (l)
                        flush_broken();
                end
                else
                begin
                    flush_broken();
                    take_fresh(b, l);
                end
            end
            else
                take_fresh(b, l);
            if (l && step_bytes.size() > 0)
                step_bytes[step_bytes.size() - 1].last = 1'b1;
            foreach (step_bytes[i])
                clean_due.push_back(step_bytes[i]);
        endfunction

        function void check_clean_byte(logic [7:0] b, logic l);
            clean_byte_t want;
            clean_count++;
            if (clean_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected output byte %02h last %0b, nothing pending", b, l);
                return;
            end
            want = clean_due.pop_front();
            if (want.data !== b || want.last !== l)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch at output %0d: expected %02h last %0b, got %02h last %0b",
                             clean_count, want.data, want.last, b, l);
            end
        endfunction

        function int unsigned pending();
            return clean_due.size();
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;

    clean_byte_board board = new();

    int unsigned burst_left  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned stall_token = 0;
    int unsigned stall_seen  = 0;
    int unsigned hold_left   = 0;
    int unsigned mode_left   = 0;
    int unsigned ready_mode  = 0;
    int unsigned ready_phase = 0;

    logic [8:0] directed_bytes [25] = '{
        9'h000, 9'h17F,                      // ASCII extremes, zero byte
        9'h0C2, 9'h080, 9'h0DF, 9'h0BF,      // two-byte lowest and highest
        9'h0E0, 9'h080, 9'h080,              // three-byte
        9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,      // four-byte ending a string
        9'h080, 9'h0C0, 9'h0F5, 9'h0FF,      // stray continuation, bad leads
        9'h0C3, 9'h0E2, 9'h082, 9'h041,      // lead broken by lead, then by ASCII
        9'h0F0, 9'h09F, 9'h180,              // string ends inside a sequence
        9'h1C3                               // lead as final byte
    };

    utf8_sanitizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Receiver: switch between stall patterns; a new stall token forces a long hold.
    always @(posedge clk)
    begin
        if (stall_token != stall_seen)
        begin
            stall_seen = stall_token;
            hold_left  = LONG_HOLD;
        end
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        ready_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((ready_phase % 7) < 4);
            endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_clean_byte(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_raw_byte(b, l);
        bytes_sent++;
    endtask

    // Hold the input idle until every expected byte has left the block.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        burst_left = 0;
    endtask

    function automatic logic [7:0] rand_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic send_random_string();
        logic [7:0]  text [$];
        int unsigned n_chars;
        int unsigned r;
        int unsigned need;
        int unsigned k;
        char_kind_e  kind;
        n_chars = $urandom_range(1, 10);
        repeat (n_chars)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                kind = CH_ASCII;
            else if (r < 45)
                kind = CH_TWO;
            else if (r < 60)
                kind = CH_THREE;
            else if (r < 72)
                kind = CH_FOUR;
            else if (r < 82)
                kind = CH_NOISE;
            else if (r < 92)
                kind = CH_CUT;
            else
                kind = CH_STRAY;
            case (kind)
                CH_ASCII: text.push_back(8'($urandom_range(0, 127)));
                CH_NOISE: text.push_back(8'($urandom_range(0, 255)));
                CH_STRAY: text.push_back(rand_cont());
                default:
                begin
                    need = (kind == CH_TWO)   ? 1 :
                           (kind == CH_THREE) ? 2 :
                           (kind == CH_FOUR)  ? 3 : $urandom_range(1, 3);
                    if (need == 1)
                        text.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                    else if (need == 2)
                        text.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
                    else
                        text.push_back(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
                    // cut sequences stop short of their continuation count
                    if (kind == CH_CUT)
                        need = $urandom_range(0, need - 1);
                    for (k = 0; k < need; k++)
                        text.push_back(rand_cont());
                end
            endcase
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        #400000;
        $display("timeout with %0d bytes still expected", board.pending());
        $display("utf8_sanitizer_tb NOT OK");
        $finish;
    end

    initial
    begin
        bit stalled;
        bit paused;
        stalled = 1'b0;
        paused  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        drain_block();

        while (bytes_sent < RANDOM_BYTES + $size(directed_bytes))
        begin
            if (!stalled && bytes_sent >= STALL_AT)
            begin
                // keep offering bytes while the receiver holds off
                stall_token++;
                stalled = 1'b1;
            end
            if (!paused && bytes_sent >= PAUSE_AT)
            begin
                drain_block();
                paused = 1'b1;
            end
            send_random_string();
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d raw bytes in %0d strings gave %0d cleaned bytes",
                 board.raw_count, board.string_count, board.clean_count);
        $display("directed cases, random text with broken sequences, a %0d-cycle output hold",
                 LONG_HOLD);
        if (board.errors == 0 && board.pending() == 0)
            $display("utf8_sanitizer_tb OK");
        else
        begin
            $display("%0d mismatches, %0d bytes still expected", board.errors, board.pending());
            $display("utf8_sanitizer_tb NOT OK");
        end
        $finish;
    end

endmodule
